// ----- rtl/hcbd_pkg.sv -----
// shared types and constants for the chunked body decoder
package hcbd_pkg;

    // parser phase, one-hot
    typedef enum logic [3:0] {
        PH_LINE = 4'b0001,
        PH_TAIL = 4'b0010,
        PH_DATA = 4'b0100,
        PH_DONE = 4'b1000
    } t_phase;

    // result status codes
    typedef enum logic [1:0] {
        ST_PAYLOAD  = 2'd0,
        ST_END      = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // one result from the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        t_status    status;
    } t_result;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // configuration register map
    localparam int unsigned APB_ADDR_W       = 3;
    localparam int unsigned APB_DATA_W       = 32;
    localparam logic        REG_CHUNKED_MODE = 1'b0;  // register index, from paddr[2]
    localparam logic        CHUNKED_MODE_RST = 1'b1;

endpackage

// ----- rtl/hcbd_if.sv -----
// request channel interfaces for body bytes in and decoded bytes out
interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       restart;

    modport source (output valid, output in_byte, output restart, input ready);
    modport sink   (input valid, input in_byte, input restart, output ready);
endinterface

interface hcbd_out_if;
    logic              valid;
    logic              ready;
    logic [7:0]        out_byte;
    hcbd_pkg::t_status status;

    modport source (output valid, output out_byte, output status, input ready);
    modport sink   (input valid, input out_byte, input status, output ready);
endinterface

// ----- rtl/hcbd_parser.sv -----
// chunked framing parser: state registers and per-byte next-state logic
module hcbd_parser #(
    parameter int unsigned SIZE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_mode,
    input  logic [7:0]        i_byte,
    input  logic              i_restart,
    output hcbd_pkg::t_result o_result
);
    import hcbd_pkg::*;

    t_phase                r_phase, n_phase;
    logic [SIZE_BITS-1:0]  r_remaining, n_remaining;
    logic [SIZE_BITS-1:0]  r_acc, n_acc;
    logic                  r_saw_digit, n_saw_digit;
    logic                  r_nonblank, n_nonblank;

    logic [SIZE_BITS-1:0]  dec_remaining;
    logic                  is_hex;
    logic [3:0]            hex_digit;

    // hex digit decode
    always_comb begin
        is_hex    = 1'b1;
        hex_digit = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            hex_digit = 4'(i_byte - 8'h30);
        end else if (i_byte >= 8'h41 && i_byte <= 8'h46) begin
            hex_digit = 4'(i_byte - 8'h37);
        end else if (i_byte >= 8'h61 && i_byte <= 8'h66) begin
            hex_digit = 4'(i_byte - 8'h57);
        end else begin
            is_hex = 1'b0;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_acc       = r_acc;
        n_saw_digit = r_saw_digit;
        n_nonblank  = r_nonblank;
        o_result    = '{valid: 1'b0, data: 8'd0, status: ST_PAYLOAD};

        if (i_restart) begin
            n_phase     = PH_LINE;
            n_remaining = '0;
            n_acc       = '0;
            n_saw_digit = 1'b0;
            n_nonblank  = 1'b0;
        end

        dec_remaining = n_remaining - {{(SIZE_BITS-1){1'b0}}, 1'b1};

        if (!i_mode) begin
            o_result = '{valid: 1'b1, data: i_byte, status: ST_PAYLOAD};
        end else begin
            case (n_phase)
                PH_DATA: begin
                    n_remaining = dec_remaining;
                    if (dec_remaining == '0) begin
                        n_phase     = PH_LINE;
                        n_acc       = '0;
                        n_saw_digit = 1'b0;
                        n_nonblank  = 1'b0;
                    end
                    o_result = '{valid: 1'b1, data: i_byte, status: ST_PAYLOAD};
                end
                PH_DONE: begin
                end
                PH_LINE, PH_TAIL: begin
                    if (i_byte == CH_LF) begin
                        // end of size line
                        if (!n_nonblank) begin
                            n_phase = PH_LINE;
                        end else if (n_saw_digit && n_acc != '0) begin
                            n_remaining = n_acc;
                            n_phase     = PH_DATA;
                        end else begin
                            n_phase  = PH_DONE;
                            o_result = '{valid: 1'b1, data: 8'd0, status: ST_END};
                        end
                        n_acc       = '0;
                        n_saw_digit = 1'b0;
                        n_nonblank  = 1'b0;
                    end else if (n_phase == PH_TAIL) begin
                        // rest of line ignored
                    end else if (i_byte == CH_CR) begin
                        if (n_saw_digit) begin
                            n_phase = PH_TAIL;
                        end
                    end else begin
                        n_nonblank = 1'b1;
                        if (i_byte == CH_SPACE && !n_saw_digit) begin
                            // leading space skipped
                        end else if (!is_hex) begin
                            n_phase = PH_TAIL;
                        end else begin
                            n_saw_digit = 1'b1;
                            if (n_acc[SIZE_BITS-1 -: 4] != 4'd0) begin
                                n_acc       = '0;
                                n_saw_digit = 1'b0;
                                n_nonblank  = 1'b0;
                                n_phase     = PH_DONE;
                                o_result    = '{valid: 1'b1, data: 8'd0,
                                                status: ST_OVERFLOW};
                            end else begin
                                n_acc = {n_acc[SIZE_BITS-5:0], hex_digit};
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_LINE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LINE;
            r_remaining <= '0;
            r_acc       <= '0;
            r_saw_digit <= 1'b0;
            r_nonblank  <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_acc       <= n_acc;
            r_saw_digit <= n_saw_digit;
            r_nonblank  <= n_nonblank;
        end
    end

endmodule

// ----- rtl/http_chunked_body_decoder.sv -----
// top level of the http chunked transfer body decoder
//
// i_in carries one body byte per request, with a restart flag that clears the
// parser before that byte. o_out carries one decoded byte per request, or a
// single end-of-body marker: status 1 for a zero or empty size line, status 2
// when a chunk size does not fit in SIZE_BITS bits. Framing bytes give no
// request on o_out.
// the apb port holds one register, chunked_mode at byte address 0; the user must
// make writes only while the block is idle; the block itself does not enforce it.
// a byte accepted at a clock edge is held in the input register, where the parser
// decodes it, and its result is registered in the result register when it moves on.
// throughput: one byte per cycle while o_out is not stalled, set by the update of
// the size accumulator and chunk counter for each byte in the parser.
// a stalled o_out keeps its result; one more byte waits in the input register
// and i_in.ready drops only when both are full and that byte makes a result.
// reset (synchronous, active low) empties both registers, sets chunked_mode
// and puts the parser at the start of a size line.
module http_chunked_body_decoder #(
    parameter int unsigned SIZE_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    hcbd_in_if.sink                             i_in,
    hcbd_out_if.source                          o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hcbd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [hcbd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [hcbd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import hcbd_pkg::*;

    // configuration
    logic    r_chunked_mode;
    logic    cfg_write;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_restart;

    // result register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    t_status    r_out_status;

    t_result    parse_res;
    logic       advance;
    logic       in_take;

    // apb: zero wait states, one register at index 0
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CHUNKED_MODE);
    assign prdata    = (paddr[2] == REG_CHUNKED_MODE)
                     ? {{(APB_DATA_W-1){1'b0}}, r_chunked_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunked_mode <= CHUNKED_MODE_RST;
        end else if (cfg_write) begin
            r_chunked_mode <= pwdata[0];
        end
    end

    // parser sees the byte held in the input register
    hcbd_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_mode    (r_chunked_mode),
        .i_byte    (r_in_byte),
        .i_restart (r_in_restart),
        .o_result  (parse_res)
    );

    // a byte moves on unless it makes a result and the result register is stuck
    assign advance    = r_in_valid && (!parse_res.valid || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte    <= i_in.in_byte;
            r_in_restart <= i_in.restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && parse_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && parse_res.valid) begin
            r_out_byte   <= parse_res.data;
            r_out_status <= parse_res.status;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.status   = r_out_status;

endmodule

// ----- tb/sv/hcbd_body_checker.sv -----
// checker that follows the body byte stream and compares the decoded requests
module hcbd_body_checker
    import hcbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    hcbd_in_if                    i_body,
    hcbd_out_if                   i_dec,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    input  logic                  i_pready,
    output int                    o_errors,
    output int                    o_pending
);

    typedef struct packed {
        logic [7:0] data;
        t_status    status;
    } t_decoded;

    t_decoded    decoded_q[$];
    logic        chunked;
    t_phase      ph;
    logic [31:0] bytes_left;
    logic [31:0] size_acc;
    logic        have_digit;
    logic        line_used;
    int          err_cnt = 0;

    function automatic void new_line();
        size_acc   = '0;
        have_digit = 1'b0;
        line_used  = 1'b0;
    endfunction

    function automatic void clear_parser();
        ph         = PH_LINE;
        bytes_left = '0;
        new_line();
    endfunction

    // lf at the end of a size line: skip a blank one, open a chunk or end the body
    function automatic logic close_line(output t_decoded d);
        d = '{data: 8'h00, status: ST_PAYLOAD};
        if (!line_used) begin
            new_line();
            ph = PH_LINE;
            return 1'b0;
        end
        if (have_digit && size_acc != 0) begin
            bytes_left = size_acc;
            new_line();
            ph = PH_DATA;
            return 1'b0;
        end
        new_line();
        ph = PH_DONE;
        d.status = ST_END;
        return 1'b1;
    endfunction

    function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
        v = 4'h0;
        if (c >= "0" && c <= "9") begin
            v = c[3:0];
            return 1'b1;
        end
        if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
            v = c[3:0] + 4'd9;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // one body byte into the parser copy; returns 1 when it yields a request
    function automatic logic decode_byte(input logic [7:0] c, input logic rs,
                                         output t_decoded d);
        logic [3:0] nib;
        d = '{data: 8'h00, status: ST_PAYLOAD};
        if (rs)
            clear_parser();
        if (!chunked) begin
            d.data = c;
            return 1'b1;
        end
        case (ph)
            PH_DATA: begin
                bytes_left = bytes_left - 1;
                if (bytes_left == 0) begin
                    ph = PH_LINE;
                    new_line();
                end
                d.data = c;
                return 1'b1;
            end
            PH_DONE: return 1'b0;
            PH_TAIL: begin
                if (c == CH_LF)
                    return close_line(d);
                return 1'b0;
            end
            default: ;
        endcase
        if (c == CH_LF)
            return close_line(d);
        if (c == CH_CR) begin
            if (have_digit)
                ph = PH_TAIL;
            return 1'b0;
        end
        line_used = 1'b1;
        if (c == CH_SPACE && !have_digit)
            return 1'b0;
        if (!hex_nibble(c, nib)) begin
            ph = PH_TAIL;
            return 1'b0;
        end
        have_digit = 1'b1;
        if (size_acc[31:28] != 4'h0) begin
            new_line();
            ph = PH_DONE;
            d.status = ST_OVERFLOW;
            return 1'b1;
        end
        size_acc = {size_acc[27:0], nib};
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_decoded want;
        t_decoded got;
        if (!i_rst_n) begin
            chunked = CHUNKED_MODE_RST;
            clear_parser();
            decoded_q.delete();
        end else begin
            if (i_dec.valid && i_dec.ready) begin
                got.data   = i_dec.out_byte;
                got.status = i_dec.status;
                if (decoded_q.size() == 0) begin
                    $error("unexpected request: out_byte %0h status %0d", got.data, got.status);
                    err_cnt++;
                end else begin
                    want = decoded_q.pop_front();
                    if (got.data !== want.data) begin
                        $error("out_byte: expected %0h, actual %0h", want.data, got.data);
                        err_cnt++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        err_cnt++;
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2] == REG_CHUNKED_MODE)
                chunked = i_pwdata[0];
            if (i_body.valid && i_body.ready) begin
                if (decode_byte(i_body.in_byte, i_body.restart, want))
                    decoded_q.push_back(want);
            end
        end
        o_errors  <= err_cnt;
        o_pending <= decoded_q.size();
    end

endmodule

// ----- tb/sv/tb.sv -----
// testbench top for the http chunked body decoder: stimulus and verdict
module tb;
    import hcbd_pkg::*;

    // one body byte together with its restart flag
    typedef struct packed {
        logic [7:0] b;
        logic       r;
    } t_body_byte;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    hcbd_in_if  body_ch ();
    hcbd_out_if dec_ch ();

    int         chk_errors;
    int         chk_pending;
    t_body_byte body_q[$];      // bytes built but not yet sent
    logic       restart_next = 1'b0;
    logic       quiet = 1'b0;   // phase without gaps or stalls
    int         sent = 0;

    http_chunked_body_decoder #(.SIZE_BITS(32)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (body_ch),
        .o_out   (dec_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hcbd_body_checker i_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_body    (body_ch),
        .i_dec     (dec_ch),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .i_pready  (pready),
        .o_errors  (chk_errors),
        .o_pending (chk_pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // queue one byte; the first byte after a restart request carries the flag
    function automatic void add(input logic [7:0] val);
        body_q.push_back('{b: val, r: restart_next});
        restart_next = 1'b0;
    endfunction

    // line end, mostly cr lf, sometimes a bare lf
    function automatic void add_eol();
        if ($urandom_range(0, 4) != 0)
            add(CH_CR);
        add(CH_LF);
    endfunction

    // n hex digits of v, letters in random case
    function automatic void add_hex(input logic [31:0] v, input int n);
        logic [3:0] nib;
        for (int i = n - 1; i >= 0; i--) begin
            nib = v[4*i +: 4];
            if (nib < 10)
                add(8'h30 + {4'h0, nib});
            else
                add(8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 10));
        end
    endfunction

    function automatic int hex_len(input logic [31:0] v);
        int n;
        n = 1;
        while (n < 8 && (v >> (4 * n)) != 0)
            n++;
        return n;
    endfunction

    // any byte that is neither a hex digit nor cr, lf or space
    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while ((b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f")
               || b == CH_LF || b == CH_CR || b == CH_SPACE);
        return b;
    endfunction

    // optional junk after the size digits: an extension or a stray byte
    function automatic void add_tail();
        logic [7:0] b;
        int         r;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            add(";");
            repeat ($urandom_range(0, 4)) begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_LF)
                    b = ";";
                add(b);
            end
        end else if (r == 2) begin
            add(non_hex_byte());
        end
    endfunction

    // one chunked body: a few well formed chunks, then an ending of some kind
    function automatic void build_body();
        int len;
        int r;
        restart_next = 1'b1;
        repeat ($urandom_range(1, 4)) begin
            // blank lines, where a lone cr is not content
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(0, 2)) add(CH_CR);
                add(CH_LF);
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) add(CH_SPACE);
            len = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 12) : $urandom_range(13, 64);
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 3)) add("0");
            add_hex(len, hex_len(len));
            add_tail();
            add_eol();
            repeat (len) add(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) != 0)
                add_eol();
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            // last chunk of size zero
            repeat ($urandom_range(1, 2)) add("0");
            add_tail();
            add_eol();
            add_eol();
        end else if (r < 72) begin
            // nine or more digits with a nonzero lead digit overflow the counter
            add_hex($urandom_range(1, 15), 1);
            add_hex($urandom, $urandom_range(8, 9));
            add_eol();
        end else if (r < 80) begin
            // eight digits still fit; the next body restarts before the line ends
            add_hex($urandom_range(1, 15), 1);
            add_hex($urandom, 7);
        end else if (r < 90) begin
            // non-blank size line without any hex digit
            if ($urandom_range(0, 1))
                repeat ($urandom_range(1, 3)) add(CH_SPACE);
            else
                add(non_hex_byte());
            add_eol();
        end else begin
            // cut off in the middle of a chunk
            add_hex($urandom_range(5, 20), 2);
            add_eol();
            repeat ($urandom_range(1, 3)) add(8'($urandom_range(0, 255)));
        end
    endfunction

    // framing characters in random order, with restarts thrown in
    function automatic void build_noise();
        int r;
        restart_next = 1'($urandom_range(0, 1));
        repeat ($urandom_range(4, 20)) begin
            if ($urandom_range(0, 15) == 0)
                restart_next = 1'b1;
            r = $urandom_range(0, 4);
            case (r)
                0: add(CH_LF);
                1: add(CH_CR);
                2: add(CH_SPACE);
                3: add_hex($urandom_range(0, 15), 1);
                default: add(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    function automatic void build_passthrough();
        repeat ($urandom_range(16, 60)) begin
            if ($urandom_range(0, 19) == 0)
                restart_next = 1'b1;
            add(8'($urandom_range(0, 255)));
        end
    endfunction

    // drain the byte queue, one request at a time, with random gaps
    task automatic send_bytes();
        t_body_byte it;
        int         n;
        while (body_q.size() != 0) begin
            it = body_q.pop_front();
            n = pick_gap();
            if (n != 0) begin
                body_ch.valid <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            body_ch.valid   <= 1'b1;
            body_ch.in_byte <= it.b;
            body_ch.restart <= it.r;
            @(posedge i_clk);
            while (!body_ch.ready) @(posedge i_clk);
            sent++;
        end
        body_ch.valid <= 1'b0;
    endtask

    // all predicted requests delivered, then a wait for bytes that give none
    task automatic wait_idle();
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // apb write of chunked_mode: setup cycle, then access until pready
    task automatic write_mode(input logic mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CHUNKED_MODE, 2'b00};
        pwdata  <= {{(APB_DATA_W - 1){1'b0}}, mode};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // receiver: ready drops for random stretches, none in quiet phases
    initial begin : rx
        int n;
        dec_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            n = pick_gap();
            if (n != 0) begin
                dec_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            dec_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    initial begin : stim
        logic mode;
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        body_ch.valid   <= 1'b0;
        body_ch.in_byte <= 8'h00;
        body_ch.restart <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, chunked mode from reset
        restart_next = 1'b1;
        add(CH_CR);                                     // blank line, lone cr ignored
        add(CH_LF);
        add(CH_SPACE);                                  // leading space, then size 3
        add("3");
        add(CH_CR);
        add(CH_LF);
        add(8'h00);                                     // payload extremes, lf as data
        add(8'hFF);
        add(CH_LF);
        add("1");                                       // extension after digit, bare lf
        add(";");
        add(CH_LF);
        add(CH_CR);                                     // cr as payload
        add("0");                                       // zero size ends the body
        add(CH_CR);
        add(CH_LF);
        add("5");                                       // ignored once the body ended
        restart_next = 1'b1;
        add(8'h09);                                     // tab is not skipped: empty size
        add(CH_LF);
        restart_next = 1'b1;
        add("f");                                       // eight digits fit, ninth overflows
        add("f");
        add("f");
        add("F");
        add("F");
        add("F");
        add("F");
        add("F");
        add("0");
        send_bytes();
        wait_idle();

        // pass-through keeps the ended parser as it is
        write_mode(1'b0);
        add(8'hA5);
        send_bytes();
        wait_idle();
        write_mode(1'b1);
        add("7");
        send_bytes();
        wait_idle();
        write_mode(1'b0);
        restart_next = 1'b1;
        add(8'h5A);
        send_bytes();
        wait_idle();

        // random phases, mostly chunked bodies
        while (sent < 820) begin
            mode = ($urandom_range(0, 3) != 0);
            write_mode(mode);
            quiet = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(2, 6)) begin
                if (!mode)
                    build_passthrough();
                else if ($urandom_range(0, 9) == 0)
                    build_noise();
                else
                    build_body();
            end
            send_bytes();
            wait_idle();
        end

        if (chk_errors == 0 && chk_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
